[hw/rtl/tgr_pkg.sv]
// ----------------------------------------------------------------------------
// tgr_pkg: shared types and constants of the touch gesture recognizer
// Event kinds, button codes, gesture codes, phase encoding and the
// configuration register map with reset values.
// ----------------------------------------------------------------------------
package tgr_pkg;

  // Event kind carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_MOVE    = 2'd2,
    KIND_TICK    = 2'd3
  } kind_e;

  // Button codes; codes two and three are ignored buttons.
  localparam logic [1:0] BTN_PRIMARY   = 2'd0;
  localparam logic [1:0] BTN_SECONDARY = 2'd1;

  // Gesture kind carried on the output tuser.
  typedef enum logic [1:0] {
    GEST_TAP    = 2'd0,
    GEST_LONG   = 2'd1,
    GEST_SCROLL = 2'd2
  } gesture_e;

  // Gesture machine phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_TOUCHING  = 4'b0010,
    PH_SCROLLING = 4'b0100,
    PH_WAIT_LIFT = 4'b1000
  } phase_e;

  // Configuration register map.
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] CFG_TAP_MAX     = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_LONG_PRESS  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_SCROLL_START = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_SCROLL_EDGE = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_SCREEN_W    = 3'd4;

  localparam logic [15:0] TAP_MAX_RST      = 16'd300;
  localparam logic [15:0] LONG_PRESS_RST   = 16'd500;
  localparam logic [11:0] SCROLL_START_RST = 12'd12;
  localparam logic [11:0] SCROLL_EDGE_RST  = 12'd0;
  localparam logic [12:0] SCREEN_W_RST     = 13'd320;

  typedef struct packed {
    logic [15:0] tap_window;
    logic [15:0] hold_time;
    logic [11:0] scroll_travel;
    logic [11:0] strip_width;
    logic [12:0] screen_width;
  } cfg_t;

endpackage

[hw/rtl/tgr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tgr_cfg_regs: configuration register file
// Write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module tgr_cfg_regs
  import tgr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TAP_MAX:      cfg_d.tap_window    = cfg_data_i[15:0];
        CFG_LONG_PRESS:   cfg_d.hold_time     = cfg_data_i[15:0];
        CFG_SCROLL_START: cfg_d.scroll_travel = cfg_data_i[11:0];
        CFG_SCROLL_EDGE:  cfg_d.strip_width   = cfg_data_i[11:0];
        CFG_SCREEN_W:     cfg_d.screen_width  = cfg_data_i[12:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_window    <= TAP_MAX_RST;
      cfg_q.hold_time     <= LONG_PRESS_RST;
      cfg_q.scroll_travel <= SCROLL_START_RST;
      cfg_q.strip_width   <= SCROLL_EDGE_RST;
      cfg_q.screen_width  <= SCREEN_W_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/tgr_in_stage.sv]
// ----------------------------------------------------------------------------
// tgr_in_stage: input event register
// Captures one event beat and holds it until the gesture core consumes it.
// ----------------------------------------------------------------------------
module tgr_in_stage
  import tgr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [1:0]            kind_i,
  input  logic [1:0]            button_i,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic [TIME_BITS-1:0]  now_i,
  input  logic                  consume_i,
  output logic                  valid_o,
  output kind_e                 kind_o,
  output logic [1:0]            button_o,
  output logic [COORD_BITS-1:0] pos_x_o,
  output logic [COORD_BITS-1:0] pos_y_o,
  output logic [TIME_BITS-1:0]  now_o
);

  logic                  valid_q, valid_d;
  logic                  load;
  kind_e                 kind_q;
  logic [1:0]            button_q;
  logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic [TIME_BITS-1:0]  now_q;

  assign ready_o = !valid_q || consume_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_e'(kind_i);
      button_q <= button_i;
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
      now_q    <= now_i;
    end
  end

  assign valid_o  = valid_q;
  assign kind_o   = kind_q;
  assign button_o = button_q;
  assign pos_x_o  = pos_x_q;
  assign pos_y_o  = pos_y_q;
  assign now_o    = now_q;

endmodule

[hw/rtl/tgr_core.sv]
// ----------------------------------------------------------------------------
// tgr_core: gesture state machine
// Decides the gesture for the registered event and updates
// the phase, press position, press time and last scroll row.
// ----------------------------------------------------------------------------
module tgr_core
  import tgr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  valid_i,
  input  kind_e                 kind_i,
  input  logic [1:0]            button_i,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic [TIME_BITS-1:0]  now_i,
  input  logic                  out_free_i,
  output logic                  consume_o,
  output logic                  push_o,
  output gesture_e              gesture_o,
  output logic [COORD_BITS-1:0] at_x_o,
  output logic [COORD_BITS-1:0] at_y_o,
  output logic [COORD_BITS:0]   delta_y_o
);

  // Widths for the signed strip and dead-zone compares.
  localparam int unsigned SW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;
  localparam int unsigned DW = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;

  phase_e                phase_q, phase_d;
  logic [TIME_BITS-1:0]  press_time_q, press_time_d;
  logic [COORD_BITS-1:0] press_x_q, press_x_d;
  logic [COORD_BITS-1:0] press_y_q, press_y_d;
  logic [COORD_BITS-1:0] last_y_q, last_y_d;

  logic [TIME_BITS-1:0]  elapsed;
  logic signed [SW-1:0]  strip_lim;
  logic signed [SW-1:0]  px_ext;
  logic                  in_strip;
  logic signed [DW-1:0]  travel;
  logic signed [DW-1:0]  start_s;
  logic                  dead_zone;
  logic                  produce;

  assign elapsed   = now_i - press_time_q;
  assign strip_lim = $signed(SW'(cfg_i.screen_width)) - $signed(SW'(cfg_i.strip_width));
  assign px_ext    = $signed(SW'(press_x_q));
  assign in_strip  = (cfg_i.strip_width != '0) && (px_ext >= strip_lim);
  assign travel    = $signed(DW'(pos_y_i)) - $signed(DW'(press_y_q));
  assign start_s   = $signed(DW'(cfg_i.scroll_travel));
  assign dead_zone = (travel > -start_s) && (travel < start_s);

  always_comb begin
    phase_d      = phase_q;
    press_time_d = press_time_q;
    press_x_d    = press_x_q;
    press_y_d    = press_y_q;
    last_y_d     = last_y_q;
    produce      = 1'b0;
    gesture_o    = GEST_TAP;
    at_x_o       = press_x_q;
    at_y_o       = press_y_q;
    delta_y_o    = '0;
    case (kind_i)
      KIND_PRESS: begin
        if (button_i == BTN_SECONDARY) begin
          // Secondary button is an instant long press at the pointer.
          produce   = 1'b1;
          gesture_o = GEST_LONG;
          at_x_o    = pos_x_i;
          at_y_o    = pos_y_i;
        end else if (button_i == BTN_PRIMARY && phase_q == PH_IDLE) begin
          press_x_d    = pos_x_i;
          press_y_d    = pos_y_i;
          press_time_d = now_i;
          phase_d      = PH_TOUCHING;
        end
      end
      KIND_RELEASE: begin
        if (button_i == BTN_PRIMARY && phase_q != PH_IDLE) begin
          if (phase_q == PH_TOUCHING && elapsed < TIME_BITS'(cfg_i.tap_window)) begin
            produce   = 1'b1;
            gesture_o = GEST_TAP;
          end
          phase_d = PH_IDLE;
        end
      end
      KIND_MOVE: begin
        if (phase_q == PH_TOUCHING) begin
          if (in_strip && !dead_zone) begin
            last_y_d = pos_y_i;
            phase_d  = PH_SCROLLING;
          end
        end else if (phase_q == PH_SCROLLING && pos_y_i != last_y_q) begin
          produce   = 1'b1;
          gesture_o = GEST_SCROLL;
          at_x_o    = pos_x_i;
          at_y_o    = pos_y_i;
          delta_y_o = {1'b0, pos_y_i} - {1'b0, last_y_q};
          last_y_d  = pos_y_i;
        end
      end
      KIND_TICK: begin
        if (phase_q == PH_TOUCHING && elapsed >= TIME_BITS'(cfg_i.hold_time)) begin
          produce   = 1'b1;
          gesture_o = GEST_LONG;
          phase_d   = PH_WAIT_LIFT;
        end
      end
      default: produce = 1'b0;
    endcase
  end

  // An event with no result never waits for the output register.
  assign consume_o = valid_i && (!produce || out_free_i);
  assign push_o    = consume_o && produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      press_time_q <= '0;
      press_x_q    <= '0;
      press_y_q    <= '0;
      last_y_q     <= '0;
    end else if (consume_o) begin
      phase_q      <= phase_d;
      press_time_q <= press_time_d;
      press_x_q    <= press_x_d;
      press_y_q    <= press_y_d;
      last_y_q     <= last_y_d;
    end
  end

endmodule

[hw/rtl/tgr_out_stage.sv]
// ----------------------------------------------------------------------------
// tgr_out_stage: result register
// Holds one gesture beat for the downstream side and reports free space.
// ----------------------------------------------------------------------------
module tgr_out_stage
  import tgr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  gesture_e              gesture_i,
  input  logic [COORD_BITS-1:0] at_x_i,
  input  logic [COORD_BITS-1:0] at_y_i,
  input  logic [COORD_BITS:0]   delta_y_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output gesture_e              gesture_o,
  output logic [COORD_BITS-1:0] at_x_o,
  output logic [COORD_BITS-1:0] at_y_o,
  output logic [COORD_BITS:0]   delta_y_o
);

  logic                  valid_q, valid_d;
  gesture_e              gesture_q;
  logic [COORD_BITS-1:0] at_x_q, at_y_q;
  logic [COORD_BITS:0]   delta_y_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      gesture_q <= gesture_i;
      at_x_q    <= at_x_i;
      at_y_q    <= at_y_i;
      delta_y_q <= delta_y_i;
    end
  end

  assign valid_o   = valid_q;
  assign gesture_o = gesture_q;
  assign at_x_o    = at_x_q;
  assign at_y_o    = at_y_q;
  assign delta_y_o = delta_y_q;

endmodule

[hw/rtl/touch_gesture_recognizer_top.sv]
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_top: tap, long press and edge-scroll detector
//
// Pointer events enter on the s_axis stream: tuser carries the event kind
// and the button, tdata the pointer position and a wrapping millisecond
// timestamp. Gestures leave on the m_axis stream: tuser carries the gesture
// kind, tdata the gesture position and the signed vertical scroll travel.
// Each event yields zero or one gesture beat.
//
// An accepted event is held in an input register; the next cycle the
// gesture machine decides it and, if it produces a gesture, loads the
// result register, which offers it on the gesture stream.
// One event per cycle is sustained unless a gesture stalls; the limit is
// the single decision stage between the two registers. Events that produce
// no gesture pass through even while the result register is full; an
// event that produces a gesture waits in the input register until the
// receiver takes the previous beat, and s_axis_tready drops only then.
//
// Reset restores config defaults, idles the machine, empties both registers.
// Write configuration on the cfg port only while the block is idle; the
// block does not enforce this. Values hold until written again.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_top
  import tgr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TIME_BITS  = 32,
  // Derived widths of the packed stream data.
  localparam int unsigned IN_W  = ((2 * COORD_BITS + TIME_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 * COORD_BITS + 1 + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Event stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_W-1:0]        s_axis_tdata,  // pos_x, pos_y, now_ms, zero pad
  input  logic [3:0]             s_axis_tuser,  // kind, button
  // Gesture stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_W-1:0]       m_axis_tdata,  // at_x, at_y, delta_y, zero pad
  output logic [1:0]             m_axis_tuser,  // gesture
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  cfg_t                  cfg;
  logic                  ev_valid;
  kind_e                 ev_kind;
  logic [1:0]            ev_button;
  logic [COORD_BITS-1:0] ev_x, ev_y;
  logic [TIME_BITS-1:0]  ev_now;
  logic                  consume, push, out_free;
  gesture_e              res_gesture, out_gesture;
  logic [COORD_BITS-1:0] res_x, res_y, out_x, out_y;
  logic [COORD_BITS:0]   res_dy, out_dy;

  tgr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tgr_in_stage #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .kind_i    (s_axis_tuser[1:0]),
    .button_i  (s_axis_tuser[3:2]),
    .pos_x_i   (s_axis_tdata[COORD_BITS-1:0]),
    .pos_y_i   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .now_i     (s_axis_tdata[2*COORD_BITS+TIME_BITS-1:2*COORD_BITS]),
    .consume_i (consume),
    .valid_o   (ev_valid),
    .kind_o    (ev_kind),
    .button_o  (ev_button),
    .pos_x_o   (ev_x),
    .pos_y_o   (ev_y),
    .now_o     (ev_now)
  );

  tgr_core #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .valid_i    (ev_valid),
    .kind_i     (ev_kind),
    .button_i   (ev_button),
    .pos_x_i    (ev_x),
    .pos_y_i    (ev_y),
    .now_i      (ev_now),
    .out_free_i (out_free),
    .consume_o  (consume),
    .push_o     (push),
    .gesture_o  (res_gesture),
    .at_x_o     (res_x),
    .at_y_o     (res_y),
    .delta_y_o  (res_dy)
  );

  tgr_out_stage #(
    .COORD_BITS (COORD_BITS)
  ) u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .gesture_i (res_gesture),
    .at_x_i    (res_x),
    .at_y_i    (res_y),
    .delta_y_i (res_dy),
    .free_o    (out_free),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .gesture_o (out_gesture),
    .at_x_o    (out_x),
    .at_y_o    (out_y),
    .delta_y_o (out_dy)
  );

  // Fields packed from bit zero up, padded with zeros to whole bytes.
  assign m_axis_tdata = OUT_W'({out_dy, out_y, out_x});
  assign m_axis_tuser = out_gesture;

endmodule

[hw/rtl/tgr_checker.sv]
// ----------------------------------------------------------------------------
// tgr_port_checks: port-level checks of the gesture recognizer
// Watches the gesture stream and is bound to the top level.
// ----------------------------------------------------------------------------
module tgr_port_checks
  import tgr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned OUT_W      = 40
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic [1:0]       m_axis_tuser
);

  logic [COORD_BITS:0] dy;
  assign dy = m_axis_tdata[3*COORD_BITS:2*COORD_BITS];

  // A stalled gesture beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("gesture beat dropped while stalled");

  // A stalled gesture beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("gesture payload changed while stalled");

  // Only tap, long press and scroll are ever reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= GEST_SCROLL)
    else $error("unknown gesture code");

  // Tap and long press carry no vertical travel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != GEST_SCROLL |-> dy == '0)
    else $error("nonzero travel on a tap or long press");

  // A scroll beat always reports some travel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == GEST_SCROLL |-> dy != '0)
    else $error("scroll beat without travel");

endmodule

bind touch_gesture_recognizer_top tgr_port_checks #(
  .COORD_BITS (COORD_BITS),
  .OUT_W      (OUT_W)
) u_tgr_port_checks (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
